### hdl/phad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phad_pkg: pose head anchor decode shared definitions
// Beat payload types, fixed-point constants, register indexes and the
// visibility sigmoid table built at elaboration.
// ----------------------------------------------------------------------------
package phad_pkg;

  localparam int MAX_SIDE        = 1280;
  localparam int FRAC_BITS       = 8;
  localparam int SIGMOID_ENTRIES = 256;

  // Field widths fixed by the item and result formats
  localparam int VAL_W   = 16;
  localparam int OUT_W   = 24;
  localparam int PROB_W  = 16;
  localparam int INDEX_W = 16;
  localparam int GRID_W  = 8;
  localparam int LEVEL_W = 2;
  localparam int REG_W   = 11;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;

  localparam logic [REG_W-1:0] IMAGE_SIDE_RESET = 11'd640;

  // Item kinds
  localparam logic KIND_BOX      = 1'b0;
  localparam logic KIND_KEYPOINT = 1'b1;

  // Sigmoid table indexing: logit clamped to +/-8, bucketed by a right shift
  localparam int SIG_IDX_W = $clog2(SIGMOID_ENTRIES);
  localparam int SIG_SHIFT = 4 + FRAC_BITS - SIG_IDX_W;
  localparam int CLAMP_W   = 4 + FRAC_BITS;

  typedef struct packed {
    logic                    req_type;
    logic signed [VAL_W-1:0] value_a;
    logic signed [VAL_W-1:0] value_b;
    logic signed [VAL_W-1:0] value_c;
    logic signed [VAL_W-1:0] value_d;
    logic [PROB_W-1:0]       score_in;
  } item_t;

  typedef struct packed {
    logic                    kind;
    logic [INDEX_W-1:0]      anchor_index;
    logic signed [OUT_W-1:0] out_a;
    logic signed [OUT_W-1:0] out_b;
    logic signed [OUT_W-1:0] out_c;
    logic signed [OUT_W-1:0] out_d;
    logic [PROB_W-1:0]       prob;
    logic                    frame_last;
  } result_t;

  // Anchor handed from the walker to the datapath with each accepted beat
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [GRID_W-1:0]  row;
    logic [GRID_W-1:0]  col;
    logic [INDEX_W-1:0] index;
    logic               frame_last;
  } anchor_t;

  // Walk request from the datapath: a beat taken, and whether it is a box
  typedef struct packed {
    logic accept;
    logic box;
  } walk_req_t;

  typedef logic [SIGMOID_ENTRIES-1:0][PROB_W-1:0] sig_table_t;

  // Unsigned quotient by shift and subtract; elaboration only
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned dvs);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= dvs) begin
        rem    = rem - dvs;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sigmoid(a) in Q0.16 for a >= 0 given in Q16; elaboration only
  function automatic longint unsigned sig_pos(longint unsigned a16);
    longint unsigned term;
    longint unsigned sum;
    longint unsigned e;
    longint unsigned den;
    term = 64'd1 << 31;
    sum  = term;
    for (int k = 1; k <= 16; k++) begin
      term = udiv64(term * a16, longint'(k) << 19);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    e = sum;
    for (int j = 0; j < 3; j++) begin
      e = (e * e) >> 31;
    end
    den = (64'd1 << 31) + e;
    return udiv64((64'd1 << 47) + (den >> 1), den);
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t      t;
    longint          c16;
    longint          x16;
    longint unsigned s;
    for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
      c16 = longint'(udiv64((2 * longint'(i) + 1) * 8 * 65536, SIGMOID_ENTRIES));
      x16 = c16 - 8 * 65536;
      if (x16 > 0) begin
        s = sig_pos(longint'(x16));
        t[i] = (s > 65535) ? 16'hFFFF : s[15:0];
      end else begin
        s = sig_pos(longint'(-x16));
        if (s > 65536) s = 65536;
        t[i] = ((65536 - s) > 65535) ? 16'hFFFF : 16'((65536 - s));
      end
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage
`default_nettype wire

### hdl/phad_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phad_if: valid/ready channels of the pose head anchor decoder
// Input channel carries raw head items, output channel decoded results.
// ----------------------------------------------------------------------------
interface phad_item_if;
  logic                 valid;
  logic                 ready;
  phad_pkg::item_t      data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface phad_result_if;
  logic                 valid;
  logic                 ready;
  phad_pkg::result_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/phad_walker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phad_walker: configuration registers and anchor walk
// Holds image size, walks anchors level by level in row-major order and
// hands out the anchor that each incoming beat belongs to.
// ----------------------------------------------------------------------------
module phad_walker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [phad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [phad_pkg::REG_W-1:0]       cfg_data,
  input  wire phad_pkg::walk_req_t              req,
  output phad_pkg::anchor_t                     anchor
);
  import phad_pkg::*;

  localparam logic [REG_W-1:0] SIDE_TOP_RAW = REG_W'(MAX_SIDE & ~31);
  localparam logic [REG_W-1:0] SIDE_MIN     = REG_W'(32);
  localparam logic [REG_W-1:0] SIDE_TOP     = (SIDE_TOP_RAW < SIDE_MIN) ? SIDE_MIN : SIDE_TOP_RAW;
  localparam logic [LEVEL_W:0] LAST_LEVEL   = 3'd2;

  logic [REG_W-1:0]   image_height;
  logic [REG_W-1:0]   image_width;
  logic [LEVEL_W-1:0] next_level, cur_level;
  logic [GRID_W-1:0]  next_row, cur_row;
  logic [GRID_W-1:0]  next_col, cur_col;
  logic [INDEX_W-1:0] next_index, cur_index;

  logic [REG_W-1:0]   side_h, side_w;
  logic [GRID_W-1:0]  next_rows, next_cols, last_rows, last_cols;
  logic [GRID_W:0]    col_inc, row_inc;
  logic [LEVEL_W:0]   level_inc;
  logic [LEVEL_W-1:0] next_level_next;
  logic [GRID_W-1:0]  next_row_next, next_col_next;
  logic [INDEX_W-1:0] next_index_next;
  logic [GRID_W-1:0]  sel_row, sel_col;
  logic [LEVEL_W-1:0] sel_level;

  function automatic logic [REG_W-1:0] eff_side(logic [REG_W-1:0] r);
    logic [REG_W-1:0] s;
    s = {r[REG_W-1:5], 5'b0};
    if (s < SIDE_MIN) s = SIDE_MIN;
    if (s > SIDE_TOP) s = SIDE_TOP;
    return s;
  endfunction

  function automatic logic [GRID_W-1:0] grid_len(logic [REG_W-1:0] side,
                                                 logic [LEVEL_W-1:0] lvl);
    logic [REG_W-1:0] g;
    g = side >> (3 + lvl);
    return g[GRID_W-1:0];
  endfunction

  // Grid sizes for the anchor a box would start, and for the last level
  always_comb begin
    side_h    = eff_side(image_height);
    side_w    = eff_side(image_width);
    next_rows = grid_len(side_h, next_level);
    next_cols = grid_len(side_w, next_level);
    last_rows = grid_len(side_h, LAST_LEVEL[LEVEL_W-1:0]);
    last_cols = grid_len(side_w, LAST_LEVEL[LEVEL_W-1:0]);
  end

  // Advance the next anchor: column, then row, then level, wrap per frame
  always_comb begin
    col_inc         = {1'b0, next_col} + 1'b1;
    row_inc         = {1'b0, next_row} + 1'b1;
    level_inc       = {1'b0, next_level};
    next_col_next   = col_inc[GRID_W-1:0];
    next_row_next   = next_row;
    if (col_inc >= {1'b0, next_cols}) begin
      next_col_next = '0;
      next_row_next = row_inc[GRID_W-1:0];
      if (row_inc >= {1'b0, next_rows}) begin
        next_row_next = '0;
        level_inc     = {1'b0, next_level} + 1'b1;
      end
    end
    if (level_inc > LAST_LEVEL) begin
      next_level_next = '0;
      next_index_next = '0;
    end else begin
      next_level_next = level_inc[LEVEL_W-1:0];
      next_index_next = next_index + 1'b1;
    end
  end

  // Anchor for the beat on the input: a box starts the next one
  always_comb begin
    sel_level = req.box ? next_level : cur_level;
    sel_row   = req.box ? next_row   : cur_row;
    sel_col   = req.box ? next_col   : cur_col;
    anchor.level = sel_level;
    anchor.row   = sel_row;
    anchor.col   = sel_col;
    anchor.index = req.box ? next_index : cur_index;
    anchor.frame_last = ({1'b0, sel_level} == LAST_LEVEL)
                     && (({1'b0, sel_row} + 1'b1) >= {1'b0, last_rows})
                     && (({1'b0, sel_col} + 1'b1) >= {1'b0, last_cols});
  end

  // Hold registers and walk state; a write to image_height or image_width restarts the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      image_height <= IMAGE_SIDE_RESET;
      image_width  <= IMAGE_SIDE_RESET;
      next_level   <= '0;
      next_row     <= '0;
      next_col     <= '0;
      next_index   <= '0;
      cur_level    <= '0;
      cur_row      <= '0;
      cur_col      <= '0;
      cur_index    <= '0;
    end else if (cfg_we && (cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_IMAGE_WIDTH)) begin
      if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end else begin
        image_width <= cfg_data;
      end
      next_level <= '0;
      next_row   <= '0;
      next_col   <= '0;
      next_index <= '0;
      cur_level  <= '0;
      cur_row    <= '0;
      cur_col    <= '0;
      cur_index  <= '0;
    end else if (req.accept && req.box) begin
      cur_level  <= next_level;
      cur_row    <= next_row;
      cur_col    <= next_col;
      cur_index  <= next_index;
      next_level <= next_level_next;
      next_row   <= next_row_next;
      next_col   <= next_col_next;
      next_index <= next_index_next;
    end
  end

  // The walk never reaches a fourth level
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, next_level} <= LAST_LEVEL) && ({1'b0, cur_level} <= LAST_LEVEL))
    else $error("walker level out of range");

  // A keypoint beat leaves the walk untouched
  assert property (@(posedge clk) disable iff (rst)
    req.accept && !req.box && !cfg_we |=> $stable(next_index) && $stable(cur_index))
    else $error("keypoint beat moved the walk");

  // The next anchor stays within its grid
  assert property (@(posedge clk) disable iff (rst)
    (next_col < next_cols) && (next_row < next_rows))
    else $error("next anchor outside grid");

endmodule
`default_nettype wire

### hdl/phad_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phad_decode: two-register decode datapath
// Captures each beat with its anchor, then forms box or keypoint
// coordinates, saturation and the sigmoid lookup into the result register.
// ----------------------------------------------------------------------------
module phad_decode (
  input  wire logic              clk,
  input  wire logic              rst,
  phad_item_if.sink              item,
  phad_result_if.source          result,
  input  wire phad_pkg::anchor_t anchor,
  output phad_pkg::walk_req_t    req
);
  import phad_pkg::*;

  localparam int W = 28;
  localparam logic signed [W-1:0] SAT_HI = W'(8388607);
  localparam logic signed [W-1:0] SAT_LO = -W'(8388608);
  localparam logic signed [VAL_W-1:0] LOGIT_HI = VAL_W'((8 << FRAC_BITS) - 1);
  localparam logic signed [VAL_W-1:0] LOGIT_LO = -VAL_W'(8 << FRAC_BITS);
  localparam logic signed [VAL_W-1:0] LOGIT_OFF = VAL_W'(8 << FRAC_BITS);

  logic    s1_valid;
  item_t   s1_item;
  anchor_t s1_anchor;
  logic    s2_free, s1_free;
  result_t res_next;

  logic signed [W-1:0]     sa, sb, sc, sd;
  logic signed [W-1:0]     cell_x, cell_y, half_x, half_y;
  logic signed [W-1:0]     pa, pb, pc, pd;
  logic signed [VAL_W-1:0] logit;
  logic [VAL_W-1:0]        logit_off;
  logic [SIG_IDX_W-1:0]    sig_idx;
  logic [2:0]              sh_stride, sh_half;

  function automatic logic signed [OUT_W-1:0] sat24(logic signed [W-1:0] v);
    if (v > SAT_HI) return OUT_W'(SAT_HI);
    if (v < SAT_LO) return OUT_W'(SAT_LO);
    return v[OUT_W-1:0];
  endfunction

  // Stall chain: result register first, then the input register
  assign s2_free    = !result.valid || result.ready;
  assign s1_free    = !s1_valid || s2_free;
  assign item.ready = s1_free;
  assign req.accept = item.valid && item.ready;
  assign req.box    = (item.data.req_type == KIND_BOX);

  // Capture the beat together with the anchor it belongs to
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= item.valid;
    end
    if (req.accept) begin
      s1_item   <= item.data;
      s1_anchor <= anchor;
    end
  end

  // Decode: strides are powers of two, so scaling is a shift
  always_comb begin
    sa = W'(s1_item.value_a);
    sb = W'(s1_item.value_b);
    sc = W'(s1_item.value_c);
    sd = W'(s1_item.value_d);
    sh_stride = 3'd3 + {1'b0, s1_anchor.level};
    sh_half   = 3'd2 + {1'b0, s1_anchor.level};
    cell_x = $signed(W'({s1_anchor.col, {FRAC_BITS{1'b0}}}));
    cell_y = $signed(W'({s1_anchor.row, {FRAC_BITS{1'b0}}}));
    half_x = $signed(W'({s1_anchor.col, 1'b1, {FRAC_BITS{1'b0}}}));
    half_y = $signed(W'({s1_anchor.row, 1'b1, {FRAC_BITS{1'b0}}}));

    // Clamp the visibility logit and bucket it into the table
    logit = s1_item.value_c;
    if (logit > LOGIT_HI) logit = LOGIT_HI;
    if (logit < LOGIT_LO) logit = LOGIT_LO;
    logit_off = VAL_W'(logit + LOGIT_OFF);
    sig_idx   = SIG_IDX_W'(logit_off[CLAMP_W-1:0] >> SIG_SHIFT);

    if (s1_item.req_type == KIND_BOX) begin
      pa = (half_x + sc - sa) <<< sh_half;
      pb = (half_y + sd - sb) <<< sh_half;
      pc = (sa + sc) <<< sh_stride;
      pd = (sb + sd) <<< sh_stride;
    end else begin
      pa = ((sa <<< 1) + cell_x) <<< sh_stride;
      pb = ((sb <<< 1) + cell_y) <<< sh_stride;
      pc = '0;
      pd = '0;
    end

    res_next.kind         = s1_item.req_type;
    res_next.anchor_index = s1_anchor.index;
    res_next.out_a        = sat24(pa);
    res_next.out_b        = sat24(pb);
    res_next.out_c        = sat24(pc);
    res_next.out_d        = sat24(pd);
    res_next.prob         = (s1_item.req_type == KIND_BOX) ? s1_item.score_in
                                                           : SIG_TABLE[sig_idx];
    res_next.frame_last   = s1_anchor.frame_last;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s2_free) begin
      result.valid <= s1_valid;
    end
    if (s2_free && s1_valid) begin
      result.data <= res_next;
    end
  end

  // A taken beat is in the input register on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    req.accept |=> s1_valid)
    else $error("accepted beat lost");

  // A stalled input register keeps its beat
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_free |=> s1_valid && $stable(s1_item) && $stable(s1_anchor))
    else $error("stalled beat changed");

  // A beat that moves on shows up as a result
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_free |=> result.valid)
    else $error("beat dropped between registers");

  // Keypoint results carry no size
  assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.data.kind == KIND_KEYPOINT) |->
      (result.data.out_c == '0) && (result.data.out_d == '0))
    else $error("keypoint result with size");

endmodule
`default_nettype wire

### hdl/pose_head_anchor_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pose_head_anchor_decode: pose detection head anchor decoder
// Turns raw box and keypoint items into pixel coordinates, sizes and
// probabilities, tracking anchor position over the stride 8/16/32 grids.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless the result side stalls, and returns one result per item.
// An accepted item is captured in the input register, tagged with its
// anchor, while the decode logic forms its result; the result register
// loads it once it is free, and the result is then offered on the output.
// The input stalls only when both registers are full and the result is not
// taken. Box items start the next anchor; keypoint items reuse the current
// one. Writing image_height or image_width restarts the walk at anchor 0;
// write them only while no item is in flight.
module pose_head_anchor_decode (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [phad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [phad_pkg::REG_W-1:0]       cfg_data,
  phad_item_if.sink                             item,
  phad_result_if.source                         result
);
  import phad_pkg::*;

  anchor_t   anchor;
  walk_req_t req;

  // Anchor walk and configuration
  phad_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .anchor    (anchor)
  );

  // Decode datapath
  phad_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .anchor (anchor),
    .req    (req)
  );

endmodule
`default_nettype wire

### verif/pose_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_decode_checker: scoreboard for the pose head anchor decoder
// Watches the register port and both channels, predicts every decoded
// result from its own anchor walk and visibility table, and compares each
// result beat field by field, in order, against the prediction.
// ----------------------------------------------------------------------------
module pose_decode_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [phad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [phad_pkg::REG_W-1:0]       cfg_data,
  phad_item_if                             item,
  phad_result_if                           result,
  output int                               mismatch_count,
  output int                               pending,
  output int                               boxes_seen,
  output int                               keypoints_seen,
  output int                               frames_seen
);
  import phad_pkg::*;

  localparam longint ONE_Q      = longint'(1) << FRAC_BITS;
  localparam longint SAT_HI     = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint SAT_LO     = -(longint'(1) << (OUT_W - 1));
  localparam int     LAST_LEVEL = 2;

  // Image size as programmed
  logic [REG_W-1:0]   height_reg;
  logic [REG_W-1:0]   width_reg;
  // Anchor the next box beat opens, and the anchor currently open
  logic [LEVEL_W-1:0] head_level;
  logic [GRID_W-1:0]  head_row;
  logic [GRID_W-1:0]  head_col;
  logic [INDEX_W-1:0] head_index;
  logic [LEVEL_W-1:0] held_level;
  logic [GRID_W-1:0]  held_row;
  logic [GRID_W-1:0]  held_col;
  logic [INDEX_W-1:0] held_index;

  logic [PROB_W-1:0]  vis_table [SIGMOID_ENTRIES];
  result_t            decoded_q [$];

  // Usable side: low five bits dropped, clamped to the supported range
  function automatic int side_of(input logic [REG_W-1:0] r);
    int s;
    int top;
    top = MAX_SIDE & ~31;
    if (top < 32) top = 32;
    s = int'(r) & 'h7E0;
    if (s < 32) s = 32;
    if (s > top) s = top;
    return s;
  endfunction

  function automatic int rows_at(input int level);
    return side_of(height_reg) >> (3 + level);
  endfunction

  function automatic int cols_at(input int level);
    return side_of(width_reg) >> (3 + level);
  endfunction

  function automatic logic signed [OUT_W-1:0] clip(input longint v);
    longint c;
    c = v;
    if (c > SAT_HI) c = SAT_HI;
    if (c < SAT_LO) c = SAT_LO;
    return c[OUT_W-1:0];
  endfunction

  // Logistic of a non-negative Q16 argument, Q0.16 rounded: e^(-a) from a
  // 16-term series of e^(-a/8) in Q31, squared three times
  function automatic longint unsigned logistic_q16(input longint unsigned a16);
    longint unsigned term;
    longint unsigned acc;
    longint unsigned ex;
    longint unsigned den;
    longint unsigned kk;
    term = 64'd1 << 31;
    acc  = term;
    for (kk = 1; kk <= 16; kk++) begin
      term = (term * a16) / (kk << 19);
      if (kk % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    ex = acc;
    repeat (3) ex = (ex * ex) >> 31;
    den = (64'd1 << 31) + ex;
    return ((64'd1 << 47) + den / 2) / den;
  endfunction

  // Fill the visibility table with the logistic at each bucket centre
  initial begin : fill_vis_table
    longint          centre;
    longint          x;
    longint unsigned s;
    int              i;
    for (i = 0; i < SIGMOID_ENTRIES; i++) begin
      centre = ((2 * longint'(i) + 1) * 8 * 65536) / SIGMOID_ENTRIES;
      x      = centre - 8 * 65536;
      if (x > 0) begin
        s = logistic_q16(x);
        vis_table[i] = (s > 65535) ? 16'hFFFF : s[PROB_W-1:0];
      end else begin
        s = logistic_q16(-x);
        if (s > 65536) s = 65536;
        s = 65536 - s;
        vis_table[i] = (s > 65535) ? 16'hFFFF : s[PROB_W-1:0];
      end
    end
  end

  // Decode one accepted item; a box beat opens the next anchor first
  function automatic result_t decode_item(input item_t it);
    result_t r;
    longint  a, b, c, d, col, row, stride, half, oa, ob, oc, od, logit;
    int      idx;
    a = it.value_a;
    b = it.value_b;
    c = it.value_c;
    d = it.value_d;
    if (it.req_type == KIND_BOX) begin
      held_level = head_level;
      held_row   = head_row;
      held_col   = head_col;
      held_index = head_index;
      head_col   = head_col + 1'b1;
      if (head_col >= cols_at(head_level)) begin
        head_col = '0;
        head_row = head_row + 1'b1;
        if (head_row >= rows_at(head_level)) begin
          head_row   = '0;
          head_level = head_level + 1'b1;
        end
      end
      if (head_level > LAST_LEVEL) begin
        head_level = '0;
        head_index = '0;
      end else begin
        head_index = head_index + 1'b1;
      end
    end
    col    = held_col;
    row    = held_row;
    stride = longint'(8) << held_level;
    half   = stride / 2;
    oc     = 0;
    od     = 0;
    if (it.req_type == KIND_BOX) begin
      oa     = ((2 * col + 1) * ONE_Q + c - a) * half;
      ob     = ((2 * row + 1) * ONE_Q + d - b) * half;
      oc     = (a + c) * stride;
      od     = (b + d) * stride;
      r.prob = it.score_in;
    end else begin
      oa    = (2 * a + col * ONE_Q) * stride;
      ob    = (2 * b + row * ONE_Q) * stride;
      logit = c;
      if (logit < -8 * ONE_Q) logit = -8 * ONE_Q;
      if (logit > 8 * ONE_Q - 1) logit = 8 * ONE_Q - 1;
      idx    = int'(((logit + 8 * ONE_Q) * SIGMOID_ENTRIES) / (16 * ONE_Q));
      r.prob = vis_table[idx];
    end
    r.kind         = it.req_type;
    r.anchor_index = held_index;
    r.out_a        = clip(oa);
    r.out_b        = clip(ob);
    r.out_c        = clip(oc);
    r.out_d        = clip(od);
    r.frame_last   = (held_level == LAST_LEVEL) &&
                     (held_row + 1 >= rows_at(LAST_LEVEL)) &&
                     (held_col + 1 >= cols_at(LAST_LEVEL));
    return r;
  endfunction

  task automatic check_field(input string fld, input logic signed [63:0] want,
                             input logic signed [63:0] got, input int anchor);
    if (got !== want) begin
      $display("%0t ns: anchor %0d %s expected %0d got %0d", $time, anchor, fld, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    result_t want;
    result_t got;
    if (rst) begin
      height_reg     = IMAGE_SIDE_RESET;
      width_reg      = IMAGE_SIDE_RESET;
      {head_level, head_row, head_col, head_index} = '0;
      {held_level, held_row, held_col, held_index} = '0;
      decoded_q.delete();
      mismatch_count = 0;
      boxes_seen     = 0;
      keypoints_seen = 0;
      frames_seen    = 0;
    end else begin
      // Register writes restart the walk; spare indexes are dropped
      if (cfg_we && (cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_IMAGE_WIDTH)) begin
        if (cfg_index == REG_IMAGE_HEIGHT) begin
          height_reg = cfg_data;
        end else begin
          width_reg = cfg_data;
        end
        {head_level, head_row, head_col, head_index} = '0;
        {held_level, held_row, held_col, held_index} = '0;
      end
      if (item.valid && item.ready) begin
        decoded_q.insert(decoded_q.size(), decode_item(item.data));
      end
      // Compare each result beat with the oldest prediction
      if (result.valid && result.ready) begin
        got = result.data;
        if (decoded_q.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, anchor %0d", $time,
                   got.anchor_index);
          mismatch_count++;
        end else begin
          want = decoded_q.pop_front();
          check_field("kind", want.kind, got.kind, want.anchor_index);
          check_field("anchor_index", want.anchor_index, got.anchor_index,
                      want.anchor_index);
          check_field("out_a", $signed(want.out_a), $signed(got.out_a), want.anchor_index);
          check_field("out_b", $signed(want.out_b), $signed(got.out_b), want.anchor_index);
          check_field("out_c", $signed(want.out_c), $signed(got.out_c), want.anchor_index);
          check_field("out_d", $signed(want.out_d), $signed(got.out_d), want.anchor_index);
          check_field("prob", want.prob, got.prob, want.anchor_index);
          check_field("frame_last", want.frame_last, got.frame_last, want.anchor_index);
          if (want.kind == KIND_BOX) begin
            boxes_seen++;
            if (want.frame_last) frames_seen++;
          end else begin
            keypoints_seen++;
          end
        end
      end
    end
    pending <= decoded_q.size();
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: pose head anchor decoder regression
// Drives directed edge items, then random anchor groups over a range of
// image sizes, with random gaps on both channels; the checker scores results.
// ----------------------------------------------------------------------------
module testbench;
  import phad_pkg::*;

  localparam int IDLE_LIMIT           = 2000;
  localparam int KEYPOINTS_PER_ANCHOR = 17;
  localparam int N_SIZES              = 9;
  // Register indexes the block does not implement
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;

  bit                     clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [REG_W-1:0]       cfg_data;

  phad_item_if   item_ch ();
  phad_result_if result_ch ();

  int mismatch_count;
  int pending;
  int boxes_seen;
  int keypoints_seen;
  int frames_seen;
  int sizes_used;
  int idle_cycles;
  bit no_idle;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pose_head_anchor_decode i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  pose_decode_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item           (item_ch),
    .result         (result_ch),
    .mismatch_count (mismatch_count),
    .pending        (pending),
    .boxes_seen     (boxes_seen),
    .keypoints_seen (keypoints_seen),
    .frames_seen    (frames_seen)
  );

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  // Mostly values near the useful range, sometimes anything, sometimes a rail
  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return VAL_W'($urandom);
      1:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return VAL_W'(int'($urandom_range(0, 5200)) - 2600);
    endcase
  endfunction

  function automatic item_t pack_item(input logic kind, input logic signed [VAL_W-1:0] a,
                                      input logic signed [VAL_W-1:0] b,
                                      input logic signed [VAL_W-1:0] c,
                                      input logic signed [VAL_W-1:0] d,
                                      input logic [PROB_W-1:0] score);
    item_t it;
    it.req_type = kind;
    it.value_a  = a;
    it.value_b  = b;
    it.value_c  = c;
    it.value_d  = d;
    it.score_in = score;
    return it;
  endfunction

  function automatic item_t make_item(input logic kind);
    return pack_item(kind, rand_value(), rand_value(), rand_value(), rand_value(),
                     PROB_W'($urandom));
  endfunction

  // Present one beat after a random gap and hold it until taken
  task automatic send_item(input item_t it);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait for every predicted result to drain
  task automatic settle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random traffic: full anchor groups, short or empty groups, and stray beats
  task automatic run_phase(input int n_items, input int full_share);
    int sent;
    int glen;
    int pick;
    sent = 0;
    // keypoint ahead of any box in this phase reuses the current anchor
    if ($urandom_range(0, 1)) begin
      send_item(make_item(KIND_KEYPOINT));
      sent++;
    end
    while (sent < n_items) begin
      if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_item(make_item($urandom_range(0, 1) ? KIND_KEYPOINT : KIND_BOX));
        sent++;
      end else begin
        glen = (pick < 15 + full_share) ? KEYPOINTS_PER_ANCHOR : $urandom_range(0, 3);
        send_item(make_item(KIND_BOX));
        repeat (glen) send_item(make_item(KIND_KEYPOINT));
        sent += 1 + glen;
      end
    end
  endtask

  // Result side: stall a random number of cycles before each beat
  initial begin : result_sink
    int w;
    result_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      w = draw_wait();
      if (w > 0) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
        repeat (w - 1) @(negedge clk);
      end
      @(negedge clk);
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  // Abort when no beat moves for too long
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int heights [N_SIZES];
    int widths  [N_SIZES];
    int counts  [N_SIZES];
    int shares  [N_SIZES];
    int i;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_IMAGE_HEIGHT;
    cfg_data      = '0;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    no_idle       = 1'b0;
    sizes_used    = 1;
    heights = '{32, 2047, 1280, 0, 32, 100, 64, 1279, 640};
    widths  = '{32, 2047, 32, 31, 1280, 200, 96, 33, 640};
    counts  = '{200, 60, 180, 200, 180, 180, 150, 180, 150};
    shares  = '{10, 60, 60, 10, 60, 40, 20, 60, 60};
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: keypoints before any box, logit clamps, field rails
    send_item(pack_item(KIND_KEYPOINT, 16'sh7FFF, 16'sh8000, 16'sd2047, 16'sd0, 16'h0000));
    send_item(pack_item(KIND_KEYPOINT, 16'sh8000, 16'sh7FFF, -16'sd2048, -16'sd1, 16'hFFFF));
    send_item(pack_item(KIND_KEYPOINT, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF, 16'h0000));
    send_item(pack_item(KIND_KEYPOINT, -16'sd1, 16'sd1, 16'sh8000, 16'sh8000, 16'h0000));
    send_item(pack_item(KIND_BOX, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF));
    send_item(pack_item(KIND_KEYPOINT, 16'sd256, 16'sd256, 16'sd0, 16'sd0, 16'h0000));
    send_item(pack_item(KIND_BOX, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0000));
    send_item(pack_item(KIND_BOX, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'h8000));
    send_item(pack_item(KIND_BOX, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'h0001));
    send_item(pack_item(KIND_BOX, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h5555));
    send_item(pack_item(KIND_KEYPOINT, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'hAAAA));
    run_phase(40, 60);

    // Random traffic over a sweep of image sizes, extremes included
    for (i = 0; i < N_SIZES; i++) begin
      settle();
      write_reg(REG_IMAGE_HEIGHT, REG_W'(heights[i]));
      write_reg(REG_IMAGE_WIDTH, REG_W'(widths[i]));
      sizes_used++;
      run_phase(counts[i], shares[i]);
      // a write to an unused index must leave the walk alone
      if (i % 3 == 1) begin
        settle();
        write_reg((i % 2 == 1) ? REG_UNUSED_3 : REG_UNUSED_2, REG_W'($urandom));
        run_phase(30, shares[i]);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    $display("Checked %0d boxes and %0d keypoints over %0d image sizes, %0d frame wraps",
             boxes_seen, keypoints_seen, sizes_used, frames_seen);
    if (mismatch_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
